// ===== design/lmk3_pkg.sv =====
// Shared constants and types for the 3x3 local-maximum keep block.
// No dependencies; used by the top level and lmk3_judge.
package lmk3_pkg;

  localparam int COLOR_W = 8;                 // one color channel
  localparam int PIXEL_W = 3 * COLOR_W;       // packed {red, green, blue}
  localparam int CFG_W = 11;                  // widest configuration register
  localparam int CFG_IDX_W = 2;               // register index on the write port

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int WIDTH_RESET = 640;
  localparam int HEIGHT_RESET = 480;

  // Which sides of the 3x3 window lie inside the image.
  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
  } nbr_mask_t;

endpackage

// ===== design/local_max_keep_3x3_core.sv =====
// 3x3 local-maximum keep on red: top level.
// Depends on lmk3_pkg, lmk3_line_ram and lmk3_judge.
//
// Raster pixels enter one request per unstalled clock; each returns unchanged when no
// in-image neighbor of its 3x3 window has a strictly larger red value, else as black.
// Throughput: one request per unstalled cycle, no bubbles; the line RAM reads one column
// ahead (the address is the next column position), so each accepted request finds its
// stored column already in the read register, and the window compare sits between that
// register and the result register. Results trail the input by image_width+1 requests;
// after image_width*image_height pixels, send image_width+1 requests with in_is_flush set
// to drain the frame. out_frame_last marks the result of the last pixel. A flush request
// during the pixel phase is taken and dropped; a pixel during the flush phase counts as
// a flush. Any write of image_width or image_height restarts the frame position; write
// registers only while the block is idle. Sizes of 0 act as 1, sizes above the maxima
// saturate. The line RAM needs no clearing pass after reset: every window tap that has
// not been written in the current frame lies outside the image and is masked.
module local_max_keep_3x3_core #(
  parameter int MAX_WIDTH = lmk3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lmk3_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [lmk3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lmk3_pkg::CFG_W-1:0]      cfg_wdata,
  // pixel requests
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_is_flush,
  input  logic [lmk3_pkg::COLOR_W-1:0]    in_red,
  input  logic [lmk3_pkg::COLOR_W-1:0]    in_green,
  input  logic [lmk3_pkg::COLOR_W-1:0]    in_blue,
  // results
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lmk3_pkg::COLOR_W-1:0]    out_red,
  output logic [lmk3_pkg::COLOR_W-1:0]    out_green,
  output logic [lmk3_pkg::COLOR_W-1:0]    out_blue,
  output logic                            out_frame_last
);

  localparam int CW = lmk3_pkg::COLOR_W;
  localparam int PW = lmk3_pkg::PIXEL_W;
  localparam int WW = $clog2(MAX_WIDTH + 1);    // clamped width value
  localparam int HW = $clog2(MAX_HEIGHT + 1);   // clamped height value
  localparam int AW = $clog2(MAX_WIDTH);        // column index
  localparam int RW = $clog2(MAX_HEIGHT + 2);   // row runs to height+1 during flush
  localparam int MW = CW + PW;                  // RAM word: {upper red, middle pixel}

  function automatic int clamp_size(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // ---------------------------------------------------------------- config
  logic [WW-1:0] w_r;
  logic [HW-1:0] h_r;
  logic          cfg_hit;

  assign cfg_hit = cfg_we &&
                   ((cfg_index == lmk3_pkg::REG_IMAGE_WIDTH) ||
                    (cfg_index == lmk3_pkg::REG_IMAGE_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= WW'(clamp_size(lmk3_pkg::WIDTH_RESET, MAX_WIDTH));
      h_r <= HW'(clamp_size(lmk3_pkg::HEIGHT_RESET, MAX_HEIGHT));
    end else if (cfg_we) begin
      if (cfg_index == lmk3_pkg::REG_IMAGE_WIDTH) begin
        w_r <= WW'(clamp_size(int'(cfg_wdata), MAX_WIDTH));
      end
      if (cfg_index == lmk3_pkg::REG_IMAGE_HEIGHT) begin
        h_r <= HW'(clamp_size(int'(cfg_wdata), MAX_HEIGHT));
      end
    end
  end

  // ---------------------------------------------------------------- position
  logic [AW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  int unsigned   cc, rr, ww, hh;
  logic          in_acc, real_phase, ignore, proc, last_item, col_nz;
  logic          out_valid_r, out_valid_nxt;

  assign cc = 32'(col_r);
  assign rr = 32'(row_r);
  assign ww = 32'(w_r);
  assign hh = 32'(h_r);

  assign in_stall   = out_valid_r && out_stall;
  assign in_acc     = in_valid && !in_stall;
  assign real_phase = rr < hh;
  assign ignore     = in_is_flush && real_phase;   // early flush: dropped
  assign proc       = in_acc && !ignore;
  assign last_item  = rr == (hh + 32'd1);          // final flush request, column 0
  assign col_nz     = col_r != '0;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (proc) begin
      if (last_item) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if ((cc + 32'd1) >= ww) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------- line store
  // Read address follows the next column so the word is ready when its request arrives.
  logic [PW-1:0] pixel;
  logic [MW-1:0] ram_rd, ram_wr;
  logic [CW-1:0] up_red, mid_red;
  logic [PW-1:0] mid_pix;

  assign pixel   = (!in_is_flush && real_phase) ? {in_red, in_green, in_blue} : '0;
  assign up_red  = ram_rd[MW-1 -: CW];
  assign mid_pix = ram_rd[PW-1:0];
  assign mid_red = mid_pix[PW-1 -: CW];
  assign ram_wr  = {mid_red, pixel};

  lmk3_line_ram #(
    .DEPTH (MAX_WIDTH),
    .DW    (MW),
    .AW    (AW)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (proc),
    .wr_addr (col_r),
    .wr_data (ram_wr),
    .rd_addr (col_nxt),
    .rd_data (ram_rd)
  );

  // ---------------------------------------------------------------- window
  // Two older columns of reds, rows upper/middle/lower; the newest column is live.
  logic [CW-1:0] old1_r [3];
  logic [CW-1:0] old2_r [3];
  logic [PW-1:0] center_r;

  always_ff @(posedge clk) begin
    if (proc) begin
      old1_r[0] <= old2_r[0];
      old1_r[1] <= old2_r[1];
      old1_r[2] <= old2_r[2];
      old2_r[0] <= up_red;
      old2_r[1] <= mid_red;
      old2_r[2] <= pixel[PW-1 -: CW];
      center_r  <= mid_pix;
    end
  end

  // ---------------------------------------------------------------- judging
  // The judged pixel sits one column back; at column 0 it is the end of the line
  // two rows up, so the row and column limits shift with col_nz.
  lmk3_pkg::nbr_mask_t        mask;
  logic                       emit, frame_last, suppress;
  logic [7:0][CW-1:0]         nbr_red;

  always_comb begin
    if (col_nz) begin
      emit       = (rr >= 32'd1) && (rr <= hh);
      mask.up    = rr >= 32'd2;
      mask.down  = rr < hh;
      mask.left  = cc >= 32'd2;
      mask.right = 1'b1;
    end else begin
      emit       = rr >= 32'd2;
      mask.up    = rr >= 32'd3;
      mask.down  = rr <= hh;
      mask.left  = ww >= 32'd2;
      mask.right = 1'b0;
    end
  end

  assign frame_last = !col_nz && last_item;

  assign nbr_red[0] = old1_r[0];
  assign nbr_red[1] = old2_r[0];
  assign nbr_red[2] = up_red;
  assign nbr_red[3] = old1_r[1];
  assign nbr_red[4] = mid_red;
  assign nbr_red[5] = old1_r[2];
  assign nbr_red[6] = old2_r[2];
  assign nbr_red[7] = pixel[PW-1 -: CW];

  lmk3_judge u_judge (
    .center_red (old2_r[1]),
    .nbr_red    (nbr_red),
    .mask       (mask),
    .suppress   (suppress)
  );

  // ---------------------------------------------------------------- result register
  logic [PW-1:0] out_pix_r;
  logic          out_last_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = proc && emit;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && emit) begin
      out_pix_r  <= suppress ? '0 : center_r;
      out_last_r <= frame_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = out_pix_r[PW-1 -: CW];
  assign out_green      = out_pix_r[PW-CW-1 -: CW];
  assign out_blue       = out_pix_r[CW-1:0];
  assign out_frame_last = out_last_r;

  // ---------------------------------------------------------------- checks
  a_col_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    32'(col_r) < 32'(w_r))
    else $error("column position beyond line width");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(row_r) <= 32'(h_r) + 32'd1)
    else $error("row position beyond flush phase");

  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> (col_r == '0) && (row_r == '0))
    else $error("frame position not restarted after last pixel");

  a_early_flush: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_is_flush && real_phase |=> !out_valid_r)
    else $error("dropped flush request produced a result");

endmodule

// ===== design/lmk3_line_ram.sv =====
// Two-line store: one synchronous-read RAM, one write and one read port.
// Depends on nothing; the read data is registered and bypasses a same-cycle write.
module lmk3_line_ram #(
  parameter int DEPTH = 1024,
  parameter int DW = 32,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // New data wins when the column just written is read again (single-pixel lines)
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/lmk3_judge.sv =====
// Suppression decision: does any in-image neighbor beat the center red value.
// Depends on lmk3_pkg (nbr_mask_t, COLOR_W).
module lmk3_judge (
  input  logic [lmk3_pkg::COLOR_W-1:0]       center_red,
  // order: up-left, up, up-right, left, right, down-left, down, down-right
  input  logic [7:0][lmk3_pkg::COLOR_W-1:0]  nbr_red,
  input  lmk3_pkg::nbr_mask_t                mask,
  output logic                               suppress
);

  logic [7:0] nbr_en;
  logic [7:0] beats;

  assign nbr_en[0] = mask.up & mask.left;
  assign nbr_en[1] = mask.up;
  assign nbr_en[2] = mask.up & mask.right;
  assign nbr_en[3] = mask.left;
  assign nbr_en[4] = mask.right;
  assign nbr_en[5] = mask.down & mask.left;
  assign nbr_en[6] = mask.down;
  assign nbr_en[7] = mask.down & mask.right;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      beats[i] = nbr_en[i] && (nbr_red[i] > center_red);
    end
  end

  assign suppress = |beats;

endmodule
